FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl core
// expects signals clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tcprx_pkg.sv
// tcprx_pkg: types, codes and structs of the tcp receive state machine
// no dependencies
package tcprx_pkg;

	// connection state codes
	typedef enum logic [3:0] {
		ST_CLOSED      = 4'd0,
		ST_LISTEN      = 4'd1,
		ST_SYN_SENT    = 4'd2,
		ST_SYN_RECV    = 4'd3,
		ST_ESTABLISHED = 4'd4,
		ST_CLOSE_WAIT  = 4'd5,
		ST_LAST_ACK    = 4'd6,
		ST_FIN_WAIT_1  = 4'd7,
		ST_FIN_WAIT_2  = 4'd8
	} state_t;

	// operation codes of an input item
	localparam logic OP_SEGMENT = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	// segment flag bits
	localparam logic [5:0] FLAG_FIN = 6'd1;
	localparam logic [5:0] FLAG_SYN = 6'd2;
	localparam logic [5:0] FLAG_RST = 6'd4;
	localparam logic [5:0] FLAG_PSH = 6'd8;
	localparam logic [5:0] FLAG_ACK = 6'd16;
	localparam logic [5:0] FLAG_URG = 6'd32;

	localparam logic [15:0] CWND_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_STOP    = 2'd1,
		TMR_RESTART = 2'd2
	} timer_t;

	typedef enum logic [1:0] {
		WAKE_NONE    = 2'd0,
		WAKE_CONNECT = 2'd1,
		WAKE_ACCEPT  = 2'd2,
		WAKE_RECEIVE = 2'd3
	} wake_t;

	// one input item
	typedef struct packed {
		logic        op;
		logic [3:0]  new_state;
		logic [5:0]  flags;
		logic [31:0] seq;
		logic [31:0] seq_end;
		logic [31:0] ack;
		logic [15:0] payload_len;
		logic [15:0] peer_window;
		logic [31:0] send_next;
		logic [15:0] recv_window_free;
		logic        retrans_timer_on;
	} item_t;

	// per-connection context
	typedef struct packed {
		state_t      state;
		logic [31:0] rcv_nxt;
		logic [31:0] una;
		logic [15:0] adv_wnd;
		logic [15:0] snd_wnd;
	} ctx_t;

	// action flags of one result
	typedef struct packed {
		logic [5:0] send_flags;
		logic       send_reset;
		logic       deliver_payload;
		logic       ack_send_buffer;
		timer_t     timer_action;
		logic       queue_out_of_order;
		wake_t      wake_target;
		logic       spawn_child;
		logic       release_socket;
	} act_t;

endpackage

FILE: rtl/core/tcprx_if.sv
// tcprx_item_if and tcprx_result_if: valid/ready channels of the block
// no dependencies
interface tcprx_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  new_state;
	logic [5:0]  flags;
	logic [31:0] seq;
	logic [31:0] seq_end;
	logic [31:0] ack;
	logic [15:0] payload_len;
	logic [15:0] peer_window;
	logic [31:0] send_next;
	logic [15:0] recv_window_free;
	logic        retrans_timer_on;

	modport source (output valid, op, new_state, flags, seq, seq_end, ack, payload_len,
		peer_window, send_next, recv_window_free, retrans_timer_on, input ready);
	modport sink (input valid, op, new_state, flags, seq, seq_end, ack, payload_len,
		peer_window, send_next, recv_window_free, retrans_timer_on, output ready);
endinterface

interface tcprx_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  conn_state;
	logic [5:0]  send_flags;
	logic        send_reset;
	logic        deliver_payload;
	logic        ack_send_buffer;
	logic [1:0]  timer_action;
	logic        queue_out_of_order;
	logic [1:0]  wake_target;
	logic        spawn_child;
	logic        release_socket;
	logic [31:0] expected_seq;
	logic [15:0] send_window;

	modport source (output valid, conn_state, send_flags, send_reset, deliver_payload,
		ack_send_buffer, timer_action, queue_out_of_order, wake_target, spawn_child,
		release_socket, expected_seq, send_window, input ready);
	modport sink (input valid, conn_state, send_flags, send_reset, deliver_payload,
		ack_send_buffer, timer_action, queue_out_of_order, wake_target, spawn_child,
		release_socket, expected_seq, send_window, output ready);
endinterface

FILE: rtl/core/tcprx_step.sv
// tcprx_step: next context and action flags for one item
// depends on tcprx_pkg
module tcprx_step (
	input  tcprx_pkg::item_t item_in,
	input  tcprx_pkg::ctx_t  ctx_cur,
	input  logic [15:0]      cwnd,
	output tcprx_pkg::ctx_t  ctx_nxt,
	output tcprx_pkg::act_t  act
);
	import tcprx_pkg::*;

	// a <= b in modulo 2^32 sequence space
	function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d == 32'd0) || d[31];
	endfunction

	// a < b in modulo 2^32 sequence space
	function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// guarded window update, applies only when una <= ack <= send_next
	function automatic ctx_t win_upd(input ctx_t c, input item_t it, input logic [15:0] cw);
		ctx_t r;
		r = c;
		if (seq_le(c.una, it.ack) && seq_le(it.ack, it.send_next)) begin
			if (it.payload_len != 16'd0)
				r.rcv_nxt = it.seq + {16'd0, it.payload_len};
			else if ((it.flags & (FLAG_FIN | FLAG_SYN)) != 6'd0)
				r.rcv_nxt = it.seq + 32'd1;
			r.una     = it.ack;
			r.adv_wnd = it.peer_window;
			r.snd_wnd = (it.peer_window < cw) ? it.peer_window : cw;
		end
		return r;
	endfunction

	logic syn_only;

	assign syn_only = (item_in.flags == FLAG_SYN) || (item_in.flags == (FLAG_SYN | FLAG_ACK));

	// state transitions and actions
	always_comb begin
		ctx_nxt = ctx_cur;
		act     = '0;
		if (item_in.op == OP_COMMAND) begin
			if (item_in.new_state <= ST_FIN_WAIT_2)
				ctx_nxt.state = state_t'(item_in.new_state);
		end else begin
			unique case (ctx_cur.state)
				ST_LISTEN: begin
					if (syn_only) begin
						act.spawn_child = 1'b1;
						act.send_flags  = FLAG_SYN | FLAG_ACK;
					end
				end
				ST_SYN_SENT: begin
					if (syn_only) begin
						ctx_nxt          = win_upd(ctx_cur, item_in, cwnd);
						ctx_nxt.state    = ST_ESTABLISHED;
						ctx_nxt.rcv_nxt  = item_in.seq + 32'd1;
						act.timer_action = TMR_STOP;
						act.send_flags   = FLAG_ACK;
						act.wake_target  = WAKE_CONNECT;
					end
				end
				ST_SYN_RECV: begin
					if (item_in.flags == FLAG_ACK) begin
						ctx_nxt          = win_upd(ctx_cur, item_in, cwnd);
						ctx_nxt.state    = ST_ESTABLISHED;
						act.timer_action = TMR_STOP;
						act.wake_target  = WAKE_ACCEPT;
					end
				end
				ST_ESTABLISHED: begin
					if (item_in.flags == FLAG_FIN) begin
						ctx_nxt         = win_upd(ctx_cur, item_in, cwnd);
						ctx_nxt.state   = ST_CLOSE_WAIT;
						act.send_flags  = FLAG_FIN | FLAG_ACK;
						act.wake_target = WAKE_RECEIVE;
					end else if (((item_in.flags & FLAG_ACK) != 6'd0)
							&& (ctx_cur.rcv_nxt == item_in.seq)) begin
						if (item_in.payload_len != 16'd0) begin
							if (item_in.payload_len > item_in.recv_window_free) begin
								act.send_reset = 1'b1;
							end else begin
								ctx_nxt             = win_upd(ctx_cur, item_in, cwnd);
								act.deliver_payload = 1'b1;
								act.send_flags      = FLAG_ACK;
								act.wake_target     = WAKE_RECEIVE;
							end
						end else begin
							ctx_nxt             = win_upd(ctx_cur, item_in, cwnd);
							act.ack_send_buffer = 1'b1;
							if (item_in.retrans_timer_on)
								act.timer_action = TMR_RESTART;
						end
					end else if (seq_lt(ctx_cur.rcv_nxt, item_in.seq)) begin
						act.send_flags         = FLAG_ACK;
						act.queue_out_of_order = 1'b1;
					end else if (seq_le(item_in.seq_end, ctx_cur.rcv_nxt)) begin
						act.send_flags = FLAG_ACK;
					end
				end
				ST_LAST_ACK: begin
					if (item_in.flags == FLAG_ACK) begin
						ctx_nxt.state      = ST_CLOSED;
						act.timer_action   = TMR_STOP;
						act.release_socket = 1'b1;
					end
				end
				ST_FIN_WAIT_1: begin
					if ((item_in.flags == FLAG_ACK) || (item_in.flags == FLAG_FIN)
							|| (item_in.flags == (FLAG_FIN | FLAG_ACK))) begin
						ctx_nxt       = win_upd(ctx_cur, item_in, cwnd);
						ctx_nxt.state = ST_FIN_WAIT_2;
					end
				end
				ST_FIN_WAIT_2: begin
					// acknowledged but the state stays in fin_wait_2
					if ((item_in.flags & FLAG_FIN) != 6'd0) begin
						ctx_nxt          = win_upd(ctx_cur, item_in, cwnd);
						act.send_flags   = FLAG_ACK;
						act.timer_action = TMR_STOP;
						act.wake_target  = WAKE_RECEIVE;
					end
				end
				default: begin
					ctx_nxt = ctx_cur;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/tcp_receive_state_machine.sv
// tcp_receive_state_machine: one-connection tcp receive state machine, top level
// depends on tcprx_pkg, tcprx_if, tcprx_step and assert_macros.svh
//
// Usage:
// - item channel takes segments (op 0) or local state commands (op 1), one
//   transaction per item; result channel gives exactly one result per item.
// - cfg_wr_en / cfg_wr_data write the congestion window; write
//   it only while the block is idle.
// - an item accepted on the item channel is held in the input register, and
//   its result is presented from the output register.
// - throughput: one item per cycle unless the result receiver stalls; the state
//   update and the window compare are one shallow step from input to output register.
// - when the result receiver stalls, the output register holds its result and
//   the input register still takes one more item; ready drops after that.
// - reset (arst_n low) puts the connection in closed with zero sequence and
//   window values, the congestion window at 65535, and empties both registers.
module tcp_receive_state_machine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [15:0]     cfg_wr_data,
	tcprx_item_if.sink      item,
	tcprx_result_if.source  result
);
	import tcprx_pkg::*;

	`include "assert_macros.svh"

	logic  valid_s1;
	item_t item_s1;
	item_t item_pk;
	logic  adv;
	logic  item_acc;
	ctx_t  ctx_q;
	ctx_t  ctx_nxt;
	act_t  act;
	logic  res_valid_q;
	act_t  act_q;
	ctx_t  res_ctx_q;
	logic [15:0] cwnd_q;

	// pack incoming transaction
	assign item_pk = '{
		op:               item.op,
		new_state:        item.new_state,
		flags:            item.flags,
		seq:              item.seq,
		seq_end:          item.seq_end,
		ack:              item.ack,
		payload_len:      item.payload_len,
		peer_window:      item.peer_window,
		send_next:        item.send_next,
		recv_window_free: item.recv_window_free,
		retrans_timer_on: item.retrans_timer_on
	};

	// handshake control
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign item_acc   = item.valid && item.ready;

	// congestion window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cwnd_q <= CWND_RESET;
		else if (cfg_wr_en)
			cwnd_q <= cfg_wr_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_acc)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item_acc)
			item_s1 <= item_pk;
	end

	// transition logic
	tcprx_step u_step (
		.item_in (item_s1),
		.ctx_cur (ctx_q),
		.cwnd    (cwnd_q),
		.ctx_nxt (ctx_nxt),
		.act     (act)
	);

	// connection context, updated as each item moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{state: ST_CLOSED, rcv_nxt: 32'd0, una: 32'd0,
				adv_wnd: 16'd0, snd_wnd: 16'd0};
		end else if (adv) begin
			ctx_q <= ctx_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_q     <= act;
			res_ctx_q <= ctx_nxt;
		end
	end

	// result channel
	assign result.valid              = res_valid_q;
	assign result.conn_state         = res_ctx_q.state;
	assign result.send_flags         = act_q.send_flags;
	assign result.send_reset         = act_q.send_reset;
	assign result.deliver_payload    = act_q.deliver_payload;
	assign result.ack_send_buffer    = act_q.ack_send_buffer;
	assign result.timer_action       = act_q.timer_action;
	assign result.queue_out_of_order = act_q.queue_out_of_order;
	assign result.wake_target        = act_q.wake_target;
	assign result.spawn_child        = act_q.spawn_child;
	assign result.release_socket     = act_q.release_socket;
	assign result.expected_seq       = res_ctx_q.rcv_nxt;
	assign result.send_window        = res_ctx_q.snd_wnd;

	// checks
	`ASSERT_NEXT(a_ctx_hold, !adv, ctx_q == $past(ctx_q), "context changed without a transaction")
	`ASSERT_ALWAYS(a_release_closed, !(res_valid_q && act_q.release_socket) || res_ctx_q.state == ST_CLOSED, "socket released while not closed")
	`ASSERT_ALWAYS(a_spawn_flags, !(res_valid_q && act_q.spawn_child) || act_q.send_flags == (FLAG_SYN | FLAG_ACK), "child spawn without syn ack")
	`ASSERT_ALWAYS(a_no_overrun, !(item_acc && valid_s1 && !adv), "input register overrun")

endmodule

FILE: tb/sv/tcp_receive_state_machine_tb.sv
`timescale 1ns / 100ps
// tcp_receive_state_machine_tb: self-checking bench for the tcp receive state machine
// depends on tcprx_pkg, tcprx_if and the tcp_receive_state_machine rtl
module tcp_receive_state_machine_tb;
	import tcprx_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int RANDOM_PHASES = 5;
	localparam int IDLE_PERCENT  = 29;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 40;

	// one expected result
	typedef struct packed {
		logic [3:0]  conn_state;
		act_t        act;
		logic [31:0] expected_seq;
		logic [15:0] send_window;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	tcprx_item_if   item_ch();
	tcprx_result_if result_ch();

	tcp_receive_state_machine uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_ch),
		.result      (result_ch)
	);

	// connection context as the bench expects it
	state_t      conn_now = ST_CLOSED;
	logic [31:0] rcv_next = '0;
	logic [31:0] snd_una  = '0;
	logic [15:0] peer_wnd = '0;
	logic [15:0] snd_wnd  = '0;
	logic [15:0] cwnd     = CWND_RESET;

	outcome_t outcome_q[$];
	int       mismatches  = 0;
	int       idle_cycles = 0;
	bit       idling_on   = 1'b1;

	always #CLK_HALF clk = ~clk;

	// wrap-around sequence compares
	function automatic logic seq_leq(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d == 32'd0) || d[31];
	endfunction

	function automatic logic seq_less(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// window update, only when snd_una <= ack <= send_next
	function automatic void update_window(item_t it);
		if (!(seq_leq(snd_una, it.ack) && seq_leq(it.ack, it.send_next)))
			return;
		if (it.payload_len != 16'd0)
			rcv_next = it.seq + it.payload_len;
		else if ((it.flags & (FLAG_FIN | FLAG_SYN)) != 6'd0)
			rcv_next = it.seq + 32'd1;
		snd_una  = it.ack;
		peer_wnd = it.peer_window;
		snd_wnd  = (peer_wnd < cwnd) ? peer_wnd : cwnd;
	endfunction

	// advance the connection by one accepted transaction and queue its result
	function automatic void record_outcome(item_t it);
		act_t     a;
		outcome_t o;
		a = '0;
		if (it.op == OP_COMMAND) begin
			if (it.new_state <= ST_FIN_WAIT_2)
				conn_now = state_t'(it.new_state);
		end else begin
			case (conn_now)
				ST_LISTEN: begin
					if (it.flags == FLAG_SYN || it.flags == (FLAG_SYN | FLAG_ACK)) begin
						a.spawn_child = 1'b1;
						a.send_flags  = FLAG_SYN | FLAG_ACK;
					end
				end
				ST_SYN_SENT: begin
					if (it.flags == FLAG_SYN || it.flags == (FLAG_SYN | FLAG_ACK)) begin
						conn_now = ST_ESTABLISHED;
						update_window(it);
						a.timer_action = TMR_STOP;
						rcv_next = it.seq + 32'd1;
						a.send_flags  = FLAG_ACK;
						a.wake_target = WAKE_CONNECT;
					end
				end
				ST_SYN_RECV: begin
					if (it.flags == FLAG_ACK) begin
						update_window(it);
						conn_now = ST_ESTABLISHED;
						a.timer_action = TMR_STOP;
						a.wake_target  = WAKE_ACCEPT;
					end
				end
				ST_ESTABLISHED: begin
					if (it.flags == FLAG_FIN) begin
						update_window(it);
						conn_now = ST_CLOSE_WAIT;
						a.send_flags  = FLAG_FIN | FLAG_ACK;
						a.wake_target = WAKE_RECEIVE;
					end else if ((it.flags & FLAG_ACK) != 6'd0 && rcv_next == it.seq) begin
						if (it.payload_len != 16'd0) begin
							if (it.payload_len > it.recv_window_free) begin
								a.send_reset = 1'b1;
							end else begin
								update_window(it);
								a.deliver_payload = 1'b1;
								a.send_flags      = FLAG_ACK;
								a.wake_target     = WAKE_RECEIVE;
							end
						end else begin
							update_window(it);
							a.ack_send_buffer = 1'b1;
							if (it.retrans_timer_on)
								a.timer_action = TMR_RESTART;
						end
					end else if (seq_less(rcv_next, it.seq)) begin
						a.send_flags         = FLAG_ACK;
						a.queue_out_of_order = 1'b1;
					end else if (seq_leq(it.seq_end, rcv_next)) begin
						a.send_flags = FLAG_ACK;
					end
				end
				ST_LAST_ACK: begin
					if (it.flags == FLAG_ACK) begin
						conn_now = ST_CLOSED;
						a.timer_action   = TMR_STOP;
						a.release_socket = 1'b1;
					end
				end
				ST_FIN_WAIT_1: begin
					if (it.flags == FLAG_ACK || it.flags == FLAG_FIN ||
							it.flags == (FLAG_FIN | FLAG_ACK)) begin
						update_window(it);
						conn_now = ST_FIN_WAIT_2;
					end
				end
				ST_FIN_WAIT_2: begin
					if ((it.flags & FLAG_FIN) != 6'd0) begin
						update_window(it);
						a.send_flags   = FLAG_ACK;
						a.timer_action = TMR_STOP;
						a.wake_target  = WAKE_RECEIVE;
					end
				end
				default: ;
			endcase
		end
		o.conn_state   = conn_now;
		o.act          = a;
		o.expected_seq = rcv_next;
		o.send_window  = snd_wnd;
		outcome_q.push_back(o);
	endfunction

	// item builders
	function automatic item_t random_fields();
		item_t it;
		it.op               = 1'($urandom);
		it.new_state        = 4'($urandom);
		it.flags            = 6'($urandom);
		it.seq              = $urandom;
		it.seq_end          = $urandom;
		it.ack              = $urandom;
		it.payload_len      = 16'($urandom);
		it.peer_window      = 16'($urandom);
		it.send_next        = $urandom;
		it.recv_window_free = 16'($urandom);
		it.retrans_timer_on = 1'($urandom);
		return it;
	endfunction

	function automatic item_t make_command(logic [3:0] code);
		item_t it;
		it = random_fields();
		it.op        = OP_COMMAND;
		it.new_state = code;
		return it;
	endfunction

	// segment whose ack falls inside the current send window
	function automatic item_t make_segment(logic [5:0] flags, logic [31:0] seq,
			logic [31:0] seq_end, logic [15:0] plen, logic [15:0] rfree);
		item_t it;
		it = random_fields();
		it.op               = OP_SEGMENT;
		it.flags            = flags;
		it.seq              = seq;
		it.seq_end          = seq_end;
		it.payload_len      = plen;
		it.recv_window_free = rfree;
		it.ack              = snd_una + 32'd100;
		it.send_next        = it.ack + 32'd100;
		return it;
	endfunction

	// mostly sequences that fit the current state, some commands and noise
	function automatic item_t random_item();
		item_t it;
		int    pick;
		int    kind;
		int    back;
		it   = random_fields();
		pick = $urandom_range(99);
		// commands, more often when the connection is parked
		if (pick < 15 || ((conn_now == ST_CLOSED || conn_now == ST_CLOSE_WAIT) && pick < 70)) begin
			it.op = OP_COMMAND;
			if ($urandom_range(9) == 0)
				it.new_state = 4'($urandom_range(15, 9));
			else
				it.new_state = 4'($urandom_range(8));
			return it;
		end
		it.op = OP_SEGMENT;
		if (pick >= 85)
			return it;
		// well-formed segment with random content
		if ($urandom_range(3) != 0) begin
			it.ack       = snd_una + $urandom_range(3000);
			it.send_next = it.ack + $urandom_range(3000);
		end
		kind = $urandom_range(9);
		if (kind < 3)
			it.payload_len = 16'd0;
		else if (kind == 3)
			it.payload_len = 16'($urandom);
		else
			it.payload_len = 16'($urandom_range(1460, 1));
		if ($urandom_range(4) == 0)
			it.recv_window_free = 16'($urandom_range(it.payload_len));
		else
			it.recv_window_free = 16'($urandom_range(65535, it.payload_len));
		it.seq     = rcv_next;
		it.seq_end = rcv_next + it.payload_len;
		case (conn_now)
			ST_LISTEN, ST_SYN_SENT: begin
				it.flags = $urandom_range(1) ? FLAG_SYN : (FLAG_SYN | FLAG_ACK);
				it.seq   = $urandom;
			end
			ST_SYN_RECV, ST_LAST_ACK: it.flags = FLAG_ACK;
			ST_FIN_WAIT_1: begin
				case ($urandom_range(2))
					0: it.flags = FLAG_ACK;
					1: it.flags = FLAG_FIN;
					default: it.flags = FLAG_FIN | FLAG_ACK;
				endcase
			end
			ST_FIN_WAIT_2: it.flags = FLAG_FIN | 6'($urandom);
			ST_ESTABLISHED: begin
				kind = $urandom_range(19);
				if (kind == 0) begin
					it.flags = FLAG_FIN;
				end else if (kind < 13) begin
					it.flags = FLAG_ACK | 6'($urandom);
				end else if (kind < 16) begin
					// ahead of the receive point
					it.flags   = FLAG_ACK | 6'($urandom);
					it.seq     = rcv_next + $urandom_range(32'h7FFF_FFFF, 1);
					it.seq_end = it.seq + it.payload_len;
				end else if (kind < 19) begin
					// old duplicate ending at or before the receive point
					back       = $urandom_range(5000, 1);
					it.flags   = FLAG_ACK | 6'($urandom);
					it.seq     = rcv_next - back;
					it.seq_end = it.seq + $urandom_range(back);
				end
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic drive_fields(item_t it);
		item_ch.op               = it.op;
		item_ch.new_state        = it.new_state;
		item_ch.flags            = it.flags;
		item_ch.seq              = it.seq;
		item_ch.seq_end          = it.seq_end;
		item_ch.ack              = it.ack;
		item_ch.payload_len      = it.payload_len;
		item_ch.peer_window      = it.peer_window;
		item_ch.send_next        = it.send_next;
		item_ch.recv_window_free = it.recv_window_free;
		item_ch.retrans_timer_on = it.retrans_timer_on;
	endtask

	// one input transaction, with random gaps before it
	task automatic send_item(item_t it);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		drive_fields(it);
		item_ch.valid = 1'b1;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		record_outcome(it);
	endtask

	// stop sending and wait until every result is back
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_congestion_window(logic [15:0] value);
		wait_idle();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cwnd = value;
	endtask

	// listen, active and passive open
	task automatic test_connection_open();
		item_t it;
		send_item(make_command(ST_LISTEN));
		// out-of-range state code leaves the state alone
		send_item(make_command(4'hF));
		send_item(make_segment(FLAG_SYN, 32'h1000, 32'h1000, 16'd0, 16'hFFFF));
		send_item(make_segment(FLAG_SYN | FLAG_ACK, 32'h2000, 32'h2000, 16'd0, 16'hFFFF));
		send_item(make_segment(FLAG_ACK, 32'h3000, 32'h3000, 16'd0, 16'hFFFF));
		send_item(make_command(ST_SYN_SENT));
		// receive point wraps to zero
		it = make_segment(FLAG_SYN | FLAG_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0);
		it.peer_window = 16'hFFFF;
		send_item(it);
		send_item(make_command(ST_SYN_RECV));
		// ack below the oldest unacked: window left as is
		it = make_segment(FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0);
		it.ack = snd_una - 32'd1;
		send_item(it);
	endtask

	// in-order data, overflow reset, pure acks, out-of-order, duplicates, fin
	task automatic test_data_transfer();
		item_t it;
		send_item(make_segment(FLAG_ACK | FLAG_PSH, rcv_next, rcv_next + 100, 16'd100, 16'd100));
		send_item(make_segment(FLAG_ACK, rcv_next, rcv_next + 16'hFFFF, 16'hFFFF, 16'hFFFE));
		it = make_segment(FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0);
		it.retrans_timer_on = 1'b1;
		send_item(it);
		it = make_segment(FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0);
		it.retrans_timer_on = 1'b0;
		send_item(it);
		send_item(make_segment(FLAG_ACK, rcv_next + 1000, rcv_next + 1100, 16'd100, 16'hFFFF));
		send_item(make_segment(FLAG_ACK, rcv_next - 50, rcv_next, 16'd50, 16'hFFFF));
		send_item(make_segment(FLAG_ACK | FLAG_URG, rcv_next - 50, rcv_next + 50, 16'd100,
			16'hFFFF));
		send_item(make_segment(FLAG_RST, rcv_next, rcv_next + 10, 16'd10, 16'hFFFF));
		send_item(make_segment(FLAG_FIN, rcv_next, rcv_next, 16'd0, 16'd0));
		send_item(make_segment(FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0));
	endtask

	// last ack, segment while closed, fin_wait_1 and fin_wait_2
	task automatic test_connection_close();
		send_item(make_command(ST_LAST_ACK));
		send_item(make_segment(FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0));
		send_item(make_segment(FLAG_SYN, rcv_next, rcv_next, 16'd0, 16'd0));
		send_item(make_command(ST_FIN_WAIT_1));
		send_item(make_segment(FLAG_FIN | FLAG_ACK, rcv_next, rcv_next, 16'd0, 16'd0));
		// payload wraps the receive point, state stays in fin_wait_2
		send_item(make_segment(FLAG_FIN | FLAG_PSH, 32'hFFFF_FFF0, 32'h0000_0010, 16'h20,
			16'hFFFF));
	endtask

	// random traffic over several congestion window settings
	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_congestion_window(16'd0);
				1: set_congestion_window(16'd1);
				2: set_congestion_window(16'($urandom));
				3: set_congestion_window(CWND_RESET);
				default: set_congestion_window(16'($urandom_range(2000)));
			endcase
			// one phase runs with no gaps at all
			idling_on = (p != 2);
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
				send_item(random_item());
		end
		idling_on = 1'b1;
	endtask

	// result receiver stalls at random
	always @(negedge clk)
		result_ch.ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// check every result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected, expected nothing, actual state %0h",
						$time, result_ch.conn_state);
			end else begin
				want = outcome_q.pop_front();
				compare_field("conn_state", want.conn_state, result_ch.conn_state);
				compare_field("send_flags", want.act.send_flags, result_ch.send_flags);
				compare_field("send_reset", want.act.send_reset, result_ch.send_reset);
				compare_field("deliver_payload", want.act.deliver_payload,
					result_ch.deliver_payload);
				compare_field("ack_send_buffer", want.act.ack_send_buffer,
					result_ch.ack_send_buffer);
				compare_field("timer_action", want.act.timer_action, result_ch.timer_action);
				compare_field("queue_out_of_order", want.act.queue_out_of_order,
					result_ch.queue_out_of_order);
				compare_field("wake_target", want.act.wake_target, result_ch.wake_target);
				compare_field("spawn_child", want.act.spawn_child, result_ch.spawn_child);
				compare_field("release_socket", want.act.release_socket,
					result_ch.release_socket);
				compare_field("expected_seq", want.expected_seq, result_ch.expected_seq);
				compare_field("send_window", want.send_window, result_ch.send_window);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin : watchdog
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[tcp_receive_state_machine] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		item_ch.valid = 1'b0;
		drive_fields('0);
		result_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_connection_open();
		test_data_transfer();
		test_connection_close();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("[tcp_receive_state_machine] OK");
		else
			$display("[tcp_receive_state_machine] ERROR");
		$finish;
	end

endmodule
